FILE: rtl/core/uvg_pkg.sv
`default_nettype none
package uvg_pkg;

    localparam int GRID_SIDE_DEF = 256;

    localparam int VIS_W   = 32;
    localparam int POS_W   = 24;
    localparam int SCALE_W = 24;
    localparam int LEN_W   = 49;
    localparam int CELL_W  = 8;
    localparam int SUM_W   = 48;
    localparam int HIT_W   = 16;
    localparam int COORD_W = 27;
    localparam int IN_W    = 128;
    localparam int OUT_W   = 112;
    localparam int ENTRY_W = 2 * SUM_W + HIT_W;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W  = $clog2(DIV_STEPS);

    localparam logic [1:0] MODE_ACC   = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_FLAGGED = 3'd1;
    localparam logic [2:0] ST_LARGE   = 3'd2;
    localparam logic [2:0] ST_SHORT   = 3'd3;
    localparam logic [2:0] ST_OFF     = 3'd4;
    localparam logic [2:0] ST_READ    = 3'd5;
    localparam logic [2:0] ST_CLEARED = 3'd6;

    localparam logic [2:0] CFG_U_SCALE = 3'd0;
    localparam logic [2:0] CFG_V_SCALE = 3'd1;
    localparam logic [2:0] CFG_MIN_LEN = 3'd2;
    localparam logic [2:0] CFG_MAX_VIS = 3'd3;
    localparam logic [2:0] CFG_UNIFORM = 3'd4;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic load_in;
        logic mul;
        logic check;
        logic mem_rd;
        logic sel2;
        logic wr_acc;
        logic wr_zero;
        logic clr_step;
        logic div_start;
        logic load_out;
    } ctl_t;

    typedef struct packed {
        logic drop;
        logic is_acc;
        logic is_clr;
        logic need_div;
        logic div_done;
        logic clr_last;
    } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/uvg_div.sv
`default_nettype none
module uvg_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [uvg_pkg::SUM_W-1:0]  dvd_a,
    input  wire logic signed [uvg_pkg::SUM_W-1:0]  dvd_b,
    input  wire logic [uvg_pkg::HIT_W-1:0]         dvs,
    output logic                                   done,
    output logic signed [uvg_pkg::SUM_W-1:0]       quo_a,
    output logic signed [uvg_pkg::SUM_W-1:0]       quo_b
);

    localparam int SW = uvg_pkg::SUM_W;
    localparam int HW = uvg_pkg::HIT_W;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [uvg_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [HW-1:0]               dvs_reg;
    logic [SW-1:0]               q_reg    [2];
    logic [SW-1:0]               q_next   [2];
    logic [HW-1:0]               rem_reg  [2];
    logic [HW-1:0]               rem_next [2];
    logic                        neg_reg  [2];
    logic signed [SW-1:0]        dvd      [2];
    logic [HW:0]                 sh       [2];
    logic                        ge       [2];

    assign dvd[0] = dvd_a;
    assign dvd[1] = dvd_b;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        for (int i = 0; i < 2; i++)
        begin
            sh[i]       = {rem_reg[i], q_reg[i][SW-1]};
            ge[i]       = sh[i] >= {1'b0, dvs_reg};
            rem_next[i] = ge[i] ? HW'(sh[i] - {1'b0, dvs_reg}) : sh[i][HW-1:0];
            q_next[i]   = {q_reg[i][SW-2:0], ge[i]};
        end
        if (busy_reg)
        begin
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            step_next = uvg_pkg::STEP_W'(uvg_pkg::DIV_STEPS - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= dvs;
            for (int i = 0; i < 2; i++)
            begin
                q_reg[i]   <= dvd[i][SW-1] ? SW'(-dvd[i]) : dvd[i];
                rem_reg[i] <= '0;
                neg_reg[i] <= dvd[i][SW-1];
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 2; i++)
            begin
                q_reg[i]   <= q_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    assign done  = done_reg;
    assign quo_a = neg_reg[0] ? $signed(SW'(-q_reg[0])) : $signed(q_reg[0]);
    assign quo_b = neg_reg[1] ? $signed(SW'(-q_reg[1])) : $signed(q_reg[1]);

endmodule
`default_nettype wire

FILE: rtl/core/uvg_datapath.sv
`default_nettype none
module uvg_datapath #(
    parameter int GRID_SIDE = uvg_pkg::GRID_SIDE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [uvg_pkg::LEN_W-1:0]     cfg_data,
    input  wire logic [uvg_pkg::IN_W-1:0]      in_data,
    input  wire logic [2:0]                    in_user,
    input  wire uvg_pkg::ctl_t                 ctl,
    output uvg_pkg::sts_t                      sts,
    output logic [uvg_pkg::OUT_W-1:0]          res_data,
    output logic [2:0]                         out_user
);

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int HALF   = GRID_SIDE / 2;
    localparam int SW     = uvg_pkg::SUM_W;
    localparam int HW     = uvg_pkg::HIT_W;
    localparam int VW     = uvg_pkg::VIS_W;
    localparam int PW     = uvg_pkg::POS_W;
    localparam int CW     = uvg_pkg::COORD_W;
    localparam logic signed [CW-1:0] HALF_C = CW'(HALF);
    localparam logic signed [CW-1:0] SIDE_C = CW'(GRID_SIDE);

    // configuration
    logic [uvg_pkg::SCALE_W-1:0]     u_scale_reg, v_scale_reg;
    logic signed [uvg_pkg::LEN_W-1:0] min_len_reg;
    logic [VW-1:0]                   max_vis_reg;
    logic                            uni_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_scale_reg <= 24'd65536;
            v_scale_reg <= 24'd65536;
            min_len_reg <= '1;
            max_vis_reg <= 32'h8000_0000;
            uni_reg     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                uvg_pkg::CFG_U_SCALE: u_scale_reg <= cfg_data[uvg_pkg::SCALE_W-1:0];
                uvg_pkg::CFG_V_SCALE: v_scale_reg <= cfg_data[uvg_pkg::SCALE_W-1:0];
                uvg_pkg::CFG_MIN_LEN: min_len_reg <= $signed(cfg_data);
                uvg_pkg::CFG_MAX_VIS: max_vis_reg <= cfg_data[VW-1:0];
                uvg_pkg::CFG_UNIFORM: uni_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // captured transaction
    logic [1:0]              mode_reg;
    logic                    flag_reg;
    logic signed [VW-1:0]    re_reg, im_reg;
    logic signed [PW-1:0]    um_reg, vm_reg;
    logic [uvg_pkg::CELL_W-1:0] cu_reg, cv_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            mode_reg <= in_user[1:0];
            flag_reg <= in_user[2];
            re_reg   <= $signed(in_data[31:0]);
            im_reg   <= $signed(in_data[63:32]);
            um_reg   <= $signed(in_data[87:64]);
            vm_reg   <= $signed(in_data[111:88]);
            cu_reg   <= in_data[119:112];
            cv_reg   <= in_data[127:120];
        end
    end

    // multiply stage
    logic signed [SW:0]   pu, pv;
    logic signed [SW-1:0] pu_reg, pv_reg;
    logic [SW-2:0]        uu_reg, vv_reg;
    logic signed [SW-1:0] uu, vv;
    logic [VW-1:0]        re_mag, im_mag;
    logic                 large_reg;

    assign pu     = um_reg * $signed({1'b0, u_scale_reg});
    assign pv     = vm_reg * $signed({1'b0, v_scale_reg});
    assign uu     = um_reg * um_reg;
    assign vv     = vm_reg * vm_reg;
    assign re_mag = re_reg[VW-1] ? VW'(-re_reg) : re_reg;
    assign im_mag = im_reg[VW-1] ? VW'(-im_reg) : im_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            pu_reg    <= pu[SW-1:0];
            pv_reg    <= pv[SW-1:0];
            uu_reg    <= uu[SW-2:0];
            vv_reg    <= vv[SW-2:0];
            large_reg <= (re_mag >= max_vis_reg) || (im_mag >= max_vis_reg);
        end
    end

    // check stage
    function automatic logic signed [PW:0] to_pix(input logic signed [SW-1:0] p);
        logic [SW-1:0] m;
        logic [SW:0]   s;
        logic [PW:0]   r;
        m = p[SW-1] ? SW'(-p) : p;
        s = {1'b0, m} + (SW+1)'(1 << 23);
        r = {1'b0, s[SW-1:24]};
        return p[SW-1] ? $signed((PW+1)'(-r)) : $signed(r);
    endfunction

    logic [SW-1:0]        len_sq;
    logic signed [PW:0]   up, vp;
    logic signed [CW-1:0] u1, u2, v1, v2;
    logic                 on_grid, longer, cell_off;
    logic [CW-1:0]        idx_a, idx_b, idx_c;
    logic [2:0]           status_next, status_reg;
    logic [ADDR_W-1:0]    idx1_reg, idx2_reg;

    always_comb
    begin
        len_sq   = {1'b0, uu_reg} + {1'b0, vv_reg};
        longer   = $signed({1'b0, len_sq}) > min_len_reg;
        up       = to_pix(pu_reg);
        vp       = to_pix(pv_reg);
        u1       = CW'(up) + HALF_C;
        v1       = CW'(vp) + HALF_C;
        u2       = HALF_C - CW'(up);
        v2       = HALF_C - CW'(vp);
        on_grid  = (u1 >= 0) && (u1 < SIDE_C) && (v1 >= 0) && (v1 < SIDE_C) &&
                   (u2 >= 0) && (u2 < SIDE_C) && (v2 >= 0) && (v2 < SIDE_C);
        idx_a    = CW'(v1 * SIDE_C + u1);
        idx_b    = CW'(v2 * SIDE_C + u2);
        cell_off = (CW'(cu_reg) >= SIDE_C) || (CW'(cv_reg) >= SIDE_C);
        idx_c    = CW'(CW'(cv_reg) * SIDE_C + CW'(cu_reg));
        if (mode_reg == uvg_pkg::MODE_ACC)
        begin
            if (flag_reg)
                status_next = uvg_pkg::ST_FLAGGED;
            else if (large_reg)
                status_next = uvg_pkg::ST_LARGE;
            else if (!longer)
                status_next = uvg_pkg::ST_SHORT;
            else if (!on_grid)
                status_next = uvg_pkg::ST_OFF;
            else
                status_next = uvg_pkg::ST_ADDED;
        end
        else if (cell_off)
            status_next = uvg_pkg::ST_OFF;
        else if (mode_reg == uvg_pkg::MODE_CLEAR)
            status_next = uvg_pkg::ST_CLEARED;
        else
            status_next = uvg_pkg::ST_READ;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.check)
        begin
            status_reg <= status_next;
            idx1_reg   <= (mode_reg == uvg_pkg::MODE_ACC) ? idx_a[ADDR_W-1:0]
                                                            : idx_c[ADDR_W-1:0];
            idx2_reg   <= idx_b[ADDR_W-1:0];
        end
    end

    // grid memory: {hits, imag, real}
    logic [uvg_pkg::ENTRY_W-1:0] grid_mem [CELLS];
    logic [uvg_pkg::ENTRY_W-1:0] rd_reg, wdata;
    logic [ADDR_W-1:0]           clr_cnt_reg, addr;
    logic                        we;
    logic signed [SW-1:0]        rd_re, rd_im;
    logic [HW-1:0]               rd_hits, hits_new;
    logic signed [VW:0]          im_op;
    logic signed [SW:0]          re_sum, im_sum;

    function automatic logic [SW-1:0] sat(input logic signed [SW:0] s);
        if (s[SW] != s[SW-1])
            return s[SW] ? uvg_pkg::SUM_MIN : uvg_pkg::SUM_MAX;
        return s[SW-1:0];
    endfunction

    always_comb
    begin
        rd_re    = $signed(rd_reg[SW-1:0]);
        rd_im    = $signed(rd_reg[2*SW-1:SW]);
        rd_hits  = rd_reg[uvg_pkg::ENTRY_W-1:2*SW];
        im_op    = ctl.sel2 ? -(VW+1)'(im_reg) : (VW+1)'(im_reg);
        re_sum   = (SW+1)'(rd_re) + (SW+1)'(re_reg);
        im_sum   = (SW+1)'(rd_im) + (SW+1)'(im_op);
        hits_new = (rd_hits == '1) ? rd_hits : rd_hits + 1'b1;
        we       = ctl.wr_acc || ctl.wr_zero || ctl.clr_step;
        wdata    = ctl.wr_acc ? {hits_new, sat(im_sum), sat(re_sum)} : '0;
        if (ctl.clr_step)
            addr = clr_cnt_reg;
        else if (ctl.sel2)
            addr = idx2_reg;
        else
            addr = idx1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            grid_mem[addr] <= wdata;
        if (ctl.mem_rd)
            rd_reg <= grid_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (ctl.clr_step)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // uniform readout
    logic                 div_done;
    logic signed [SW-1:0] q_re, q_im;

    uvg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .dvd_a (rd_re),
        .dvd_b (rd_im),
        .dvs   (rd_hits),
        .done  (div_done),
        .quo_a (q_re),
        .quo_b (q_im)
    );

    // result
    logic [2:0]    out_status_reg;
    logic [SW-1:0] out_re_reg, out_im_reg;
    logic [HW-1:0] out_cnt_reg;
    logic          need_div;

    assign need_div = uni_reg && (rd_hits != '0);

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            out_status_reg <= status_reg;
            if (status_reg == uvg_pkg::ST_READ)
            begin
                out_cnt_reg <= rd_hits;
                out_re_reg  <= need_div ? q_re : (uni_reg ? '0 : rd_re);
                out_im_reg  <= need_div ? q_im : (uni_reg ? '0 : rd_im);
            end
            else
            begin
                out_cnt_reg <= '0;
                out_re_reg  <= '0;
                out_im_reg  <= '0;
            end
        end
    end

    assign res_data = {out_cnt_reg, out_im_reg, out_re_reg};
    assign out_user = out_status_reg;

    assign sts.drop     = (status_reg != uvg_pkg::ST_ADDED) &&
                          (status_reg != uvg_pkg::ST_READ) &&
                          (status_reg != uvg_pkg::ST_CLEARED);
    assign sts.is_acc   = mode_reg == uvg_pkg::MODE_ACC;
    assign sts.is_clr   = mode_reg == uvg_pkg::MODE_CLEAR;
    assign sts.need_div = need_div;
    assign sts.div_done = div_done;
    assign sts.clr_last = clr_cnt_reg == ADDR_W'(CELLS - 1);

endmodule
`default_nettype wire

FILE: rtl/core/uvg_ctrl.sv
`default_nettype none
module uvg_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire uvg_pkg::sts_t  sts,
    output uvg_pkg::ctl_t       ctl
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_DEC  = 4'd4;
    localparam logic [3:0] S_RD1  = 4'd5;
    localparam logic [3:0] S_WR1  = 4'd6;
    localparam logic [3:0] S_RD2  = 4'd7;
    localparam logic [3:0] S_WR2  = 4'd8;
    localparam logic [3:0] S_WZ   = 4'd9;
    localparam logic [3:0] S_RDC  = 4'd10;
    localparam logic [3:0] S_RDW  = 4'd11;
    localparam logic [3:0] S_DIV  = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       slot_free;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = ovalid_reg;
    assign slot_free = !ovalid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ctl         = '0;
        case (state_reg)
            S_CLR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                ctl.check  = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (sts.drop)
                    state_next = S_OUT;
                else if (sts.is_acc)
                    state_next = S_RD1;
                else if (sts.is_clr)
                    state_next = S_WZ;
                else
                    state_next = S_RDC;
            end
            S_RD1:
            begin
                ctl.mem_rd = 1'b1;
                state_next = S_WR1;
            end
            S_WR1:
            begin
                ctl.wr_acc = 1'b1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                ctl.mem_rd = 1'b1;
                ctl.sel2   = 1'b1;
                state_next = S_WR2;
            end
            S_WR2:
            begin
                ctl.wr_acc = 1'b1;
                ctl.sel2   = 1'b1;
                state_next = S_OUT;
            end
            S_WZ:
            begin
                ctl.wr_zero = 1'b1;
                state_next  = S_OUT;
            end
            S_RDC:
            begin
                ctl.mem_rd = 1'b1;
                state_next = S_RDW;
            end
            S_RDW:
            begin
                if (sts.need_div)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    state_next = S_OUT;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the result register is free
                if (slot_free)
                begin
                    ctl.load_out = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_MUL)
        else $error("accepted transaction did not start");

    a_div_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && sts.div_done |=> state_reg == S_OUT)
        else $error("divide result not forwarded");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_acc |-> state_reg == S_WR1 || state_reg == S_WR2)
        else $error("grid update outside write step");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> !ovalid_reg || out_ready)
        else $error("result overwritten before taken");

endmodule
`default_nettype wire

FILE: rtl/core/uv_visibility_gridder.sv
// Nearest-neighbour UV gridder.
// Slave stream s_*: one transaction per command. s_tuser carries mode and
// flagged, s_tdata the visibility, the baseline u,v and the cell address.
// Master stream m_*: exactly one result transaction per command, m_tuser
// carries the status, m_tdata the cell sums and hit count of a read.
// Config port: cfg_wr_en/cfg_index/cfg_data write a register; write only
// while the block is idle.
// Sequencing: one command at a time. A rejected command gives its result
// after the multiply, check and decide steps; a raw read adds one grid read,
// an accepted visibility two read-modify-writes on the single grid memory
// port (cell then mirror), a clear one zero write. A uniform-weighted read of
// a non-empty cell adds the bit-serial divide (one quotient bit per cycle).
// Reset: the grid memory is swept to zero, one cell per cycle, covering all
// GRID_SIDE*GRID_SIDE cells (65536 by default); s_tready stays low meanwhile.
// Stall: a result waits in the output register while m_tready is low; the
// next command is accepted but holds before loading its result.
`default_nettype none
module uv_visibility_gridder #(
    parameter int GRID_SIDE = uvg_pkg::GRID_SIDE_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [uvg_pkg::LEN_W-1:0]    cfg_data,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // vis_real, vis_imag, u_metres, v_metres, cell_u, cell_v
    input  wire logic [uvg_pkg::IN_W-1:0]     s_tdata,
    // mode, flagged
    input  wire logic [2:0]                   s_tuser,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // cell_real, cell_imag, cell_count
    output logic [uvg_pkg::OUT_W-1:0]         m_tdata,
    // status
    output logic [2:0]                        m_tuser
);

    uvg_pkg::ctl_t ctl;
    uvg_pkg::sts_t sts;

    uvg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .ctl       (ctl)
    );

    uvg_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .ctl       (ctl),
        .sts       (sts),
        .res_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule
`default_nettype wire

FILE: tb/uv_visibility_gridder_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module uv_visibility_gridder_tb;

    localparam int SIDE = uvg_pkg::GRID_SIDE_DEF;
    localparam int HALF = SIDE / 2;
    localparam int CELLS = SIDE * SIDE;
    localparam int IDLE_LIMIT = 200000;
    // mode three behaves as a read
    localparam logic [1:0] MODE_ALT_READ = 2'd3;

    typedef struct packed {
        logic [1:0]          mode;
        logic signed [31:0]  re;
        logic signed [31:0]  im;
        logic                flag;
        logic signed [23:0]  um;
        logic signed [23:0]  vm;
        logic [7:0]          cu;
        logic [7:0]          cv;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    typedef struct packed {
        logic [2:0]          status;
        logic signed [47:0]  creal;
        logic signed [47:0]  cimag;
        logic [15:0]         ccount;
    } res_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [2:0]                   cfg_index;
    logic [uvg_pkg::LEN_W-1:0]    cfg_data;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [uvg_pkg::IN_W-1:0]     s_tdata;
    logic [2:0]                   s_tuser;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [uvg_pkg::OUT_W-1:0]    m_tdata;
    logic [2:0]                   m_tuser;

    // golden grid and registers
    logic signed [47:0]  g_re [CELLS];
    logic signed [47:0]  g_im [CELLS];
    logic [15:0]         g_hits [CELLS];
    logic [23:0]         r_u_scale;
    logic [23:0]         r_v_scale;
    logic signed [48:0]  r_min_len;
    logic [31:0]         r_max_vis;
    logic                r_uniform;

    res_t  pending_results[$];
    int    errors;
    int    sent;
    int    received;
    int    idle_cycles;
    bit    quiet_stretch;

    uv_visibility_gridder uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [63:0] pixel_of(logic signed [23:0] c, logic [23:0] sc);
        logic signed [63:0] prod;
        logic [63:0] m;
        logic signed [63:0] r;
        begin
            prod = 64'(c) * $signed({40'd0, sc});
            m = prod < 0 ? -prod : prod;
            r = $signed((m + 64'd8388608) >> 24);
            return prod < 0 ? -r : r;
        end
    endfunction

    function automatic logic signed [47:0] sat48(logic signed [63:0] s);
        begin
            if (s > 64'sd140737488355327)
                return uvg_pkg::SUM_MAX;
            if (s < -64'sd140737488355328)
                return uvg_pkg::SUM_MIN;
            return s[47:0];
        end
    endfunction

    function automatic logic signed [47:0] cell_avg(logic signed [47:0] s, logic [15:0] n);
        logic [63:0] q;
        begin
            if (n == 0)
                return '0;
            q = (s < 0 ? -64'(s) : 64'(s)) / n;
            return s < 0 ? -q[47:0] : q[47:0];
        end
    endfunction

    function automatic void grid_add(int idx, logic signed [63:0] re, logic signed [63:0] im);
        begin
            g_re[idx] = sat48(64'(g_re[idx]) + re);
            g_im[idx] = sat48(64'(g_im[idx]) + im);
            if (g_hits[idx] != 16'hFFFF)
                g_hits[idx] = g_hits[idx] + 16'd1;
        end
    endfunction

    // apply one command to the golden grid and return its result
    function automatic res_t grid_step(cmd_t c);
        res_t r;
        logic signed [63:0] len_sq, up, vp, u1, v1, u2, v2, re, im;
        logic [63:0] mre, mim;
        int idx;
        begin
            r = '0;
            re = 64'(c.re);
            im = 64'(c.im);
            if (c.mode == uvg_pkg::MODE_ACC)
            begin
                len_sq = 64'(c.um) * 64'(c.um) + 64'(c.vm) * 64'(c.vm);
                mre = re < 0 ? -re : re;
                mim = im < 0 ? -im : im;
                if (c.flag)
                    r.status = uvg_pkg::ST_FLAGGED;
                else if (mre >= r_max_vis || mim >= r_max_vis)
                    r.status = uvg_pkg::ST_LARGE;
                else if (!(len_sq > 64'(r_min_len)))
                    r.status = uvg_pkg::ST_SHORT;
                else
                begin
                    up = pixel_of(c.um, r_u_scale);
                    vp = pixel_of(c.vm, r_v_scale);
                    u1 = up + HALF;
                    v1 = vp + HALF;
                    u2 = HALF - up;
                    v2 = HALF - vp;
                    if (u1 < 0 || u1 >= SIDE || v1 < 0 || v1 >= SIDE ||
                        u2 < 0 || u2 >= SIDE || v2 < 0 || v2 >= SIDE)
                        r.status = uvg_pkg::ST_OFF;
                    else
                    begin
                        grid_add(int'(v1 * SIDE + u1), re, im);
                        grid_add(int'(v2 * SIDE + u2), re, -im);
                        r.status = uvg_pkg::ST_ADDED;
                    end
                end
            end
            else
            begin
                idx = int'(c.cv) * SIDE + int'(c.cu);
                if (c.mode == uvg_pkg::MODE_CLEAR)
                begin
                    g_re[idx] = '0;
                    g_im[idx] = '0;
                    g_hits[idx] = '0;
                    r.status = uvg_pkg::ST_CLEARED;
                end
                else
                begin
                    r.status = uvg_pkg::ST_READ;
                    r.ccount = g_hits[idx];
                    r.creal = r_uniform ? cell_avg(g_re[idx], g_hits[idx]) : g_re[idx];
                    r.cimag = r_uniform ? cell_avg(g_im[idx], g_hits[idx]) : g_im[idx];
                end
            end
            return r;
        end
    endfunction

    function automatic bit roll_idle();
        return !quiet_stretch && ($urandom_range(99) < 38);
    endfunction

    // valid stays up after a transaction until the next send or a drain drops it
    task automatic send_cmd(cmd_t c);
        begin
            while (roll_idle())
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= {c.flag, c.mode};
            s_tdata  <= {16'd0, c.cv, c.cu, c.vm, c.um, c.im, c.re};
            do
                @(posedge clk);
            while (!s_tready);
            pending_results.push_back(grid_step(c));
            sent++;
        end
    endtask

    task automatic wait_drained();
        begin
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            // settle before touching configuration
            repeat (80) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [2:0] index, logic [uvg_pkg::LEN_W-1:0] value);
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= index;
            cfg_data  <= value;
            @(posedge clk);
            case (index)
                uvg_pkg::CFG_U_SCALE: r_u_scale = value[23:0];
                uvg_pkg::CFG_V_SCALE: r_v_scale = value[23:0];
                uvg_pkg::CFG_MIN_LEN: r_min_len = value;
                uvg_pkg::CFG_MAX_VIS: r_max_vis = value[31:0];
                uvg_pkg::CFG_UNIFORM: r_uniform = value[0];
                default: ;
            endcase
        end
    endtask

    task automatic configure(logic [23:0] us, logic [23:0] vs, logic [48:0] ml,
                             logic [31:0] mv, logic uw);
        begin
            wait_drained();
            write_reg(uvg_pkg::CFG_U_SCALE, uvg_pkg::LEN_W'(us));
            write_reg(uvg_pkg::CFG_V_SCALE, uvg_pkg::LEN_W'(vs));
            write_reg(uvg_pkg::CFG_MIN_LEN, ml);
            write_reg(uvg_pkg::CFG_MAX_VIS, uvg_pkg::LEN_W'(mv));
            write_reg(uvg_pkg::CFG_UNIFORM, uvg_pkg::LEN_W'(uw));
            cfg_wr_en <= 1'b0;
        end
    endtask

    function automatic cmd_t make_acc(logic signed [31:0] re, logic signed [31:0] im,
                                      logic signed [23:0] um, logic signed [23:0] vm);
        cmd_t c;
        begin
            c = '0;
            c.mode = uvg_pkg::MODE_ACC;
            c.re = re;
            c.im = im;
            c.um = um;
            c.vm = vm;
            c.cu = 8'($urandom);
            c.cv = 8'($urandom);
            return c;
        end
    endfunction

    function automatic cmd_t make_cell(logic [1:0] mode, logic [7:0] cu, logic [7:0] cv);
        cmd_t c;
        begin
            c = cmd_t'(CMD_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
            c.mode = mode;
            c.cu = cu;
            c.cv = cv;
            return c;
        end
    endfunction

    // coordinate near the center so most items land on the grid
    function automatic logic signed [23:0] near_coord();
        return $urandom_range(3) == 0 ? 24'($urandom) : 24'($signed($urandom_range(16000)) - 8000);
    endfunction

    task automatic test_directed();
        cmd_t c;
        begin
            send_cmd(make_acc(32'sd1000, 32'sd77, 24'sd0, 24'sd0));          // same cell
            send_cmd(make_cell(uvg_pkg::MODE_READ, 8'd128, 8'd128));
            send_cmd(make_acc(32'sd5, -32'sd9, 24'sd128, -24'sd384));         // half rounding
            send_cmd(make_cell(uvg_pkg::MODE_READ, 8'd129, 8'd126));
            send_cmd(make_cell(uvg_pkg::MODE_READ, 8'd127, 8'd130));
            c = make_acc(32'sd1, 32'sd1, 24'sd256, 24'sd256);
            c.flag = 1'b1;
            send_cmd(c);
            send_cmd(make_acc(32'h8000_0000, 32'sd0, 24'sd256, 24'sd0));       // too large
            send_cmd(make_acc(32'sd0, 32'h7FFF_FFFF, 24'sd256, 24'sd0));
            send_cmd(make_acc(32'sd3, 32'sd3, 24'h7FFFFF, 24'sd0));            // off grid
            send_cmd(make_acc(32'sd3, 32'sd3, 24'sd0, 24'h800000));
            send_cmd(make_acc(32'sd3, 32'sd3, 24'sd32512, 24'sd0));            // u_pix 127
            send_cmd(make_acc(32'sd3, 32'sd3, -24'sd32768, 24'sd0));           // mirror off
            send_cmd(make_cell(uvg_pkg::MODE_READ, 8'd255, 8'd128));
            send_cmd(make_cell(uvg_pkg::MODE_READ, 8'd1, 8'd128));
            send_cmd(make_cell(uvg_pkg::MODE_CLEAR, 8'd128, 8'd128));
            send_cmd(make_cell(uvg_pkg::MODE_READ, 8'd128, 8'd128));
            send_cmd(make_cell(MODE_ALT_READ, 8'd0, 8'd0));
            send_cmd(make_cell(uvg_pkg::MODE_READ, 8'd255, 8'd255));
        end
    endtask

    task automatic test_saturation();
        begin
            configure(24'hFFFFFF, 24'hFFFFFF, 49'd1 << 47, 32'hFFFF_FFFF, 1'b1);
            send_cmd(make_acc(32'sd7, 32'sd7, 24'sd0, 24'sd0));                // too short
            configure(24'd0, 24'd0, '1, 32'hFFFF_FFFF, 1'b0);
            // zero scale maps everything to the center cell
            repeat (40) send_cmd(make_acc(32'h8000_0000, 32'h7FFF_FFFF, 24'($urandom), 24'sd1));
            send_cmd(make_cell(uvg_pkg::MODE_READ, 8'd128, 8'd128));
            configure(24'd0, 24'd0, '1, 32'd0, 1'b1);
            send_cmd(make_acc(32'sd0, 32'sd0, 24'sd5, 24'sd5));                // max_vis 0
            send_cmd(make_cell(uvg_pkg::MODE_READ, 8'd128, 8'd128));
            send_cmd(make_cell(uvg_pkg::MODE_CLEAR, 8'd128, 8'd128));
            send_cmd(make_cell(uvg_pkg::MODE_READ, 8'd128, 8'd128));           // empty uniform
        end
    endtask

    task automatic test_random(int n, bit uniform_on);
        cmd_t c;
        int k;
        begin
            configure(24'($urandom_range(2000, 300000)), 24'($urandom_range(2000, 300000)),
                      $urandom_range(0, 3) == 0 ? 49'($urandom_range(100000000)) : '1,
                      $urandom_range(1) ? 32'h8000_0000 : 32'($urandom), uniform_on);
            for (k = 0; k < n; k++)
            begin
                quiet_stretch = (k >= n / 3) && (k < n / 3 + 60);
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        c = make_acc($urandom, $urandom, near_coord(), near_coord());
                        c.flag = ($urandom_range(19) == 0);
                        if ($urandom_range(1))
                        begin
                            c.re = $signed(c.re) >>> $urandom_range(31);
                            c.im = $signed(c.im) >>> $urandom_range(31);
                        end
                    end
                    6, 7, 8: c = make_cell(uvg_pkg::MODE_READ, 8'($urandom_range(96, 160)),
                                            8'($urandom_range(96, 160)));
                    default: c = make_cell($urandom_range(1) ? uvg_pkg::MODE_CLEAR
                                                             : MODE_ALT_READ,
                                           8'($urandom), 8'($urandom));
                endcase
                send_cmd(c);
            end
            quiet_stretch = 1'b0;
        end
    endtask

    // result checker and sink backpressure
    always @(posedge clk)
    begin
        res_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.creal  = m_tdata[47:0];
                got.cimag  = m_tdata[95:48];
                got.ccount = m_tdata[111:96];
                received++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $error("unexpected result status=%0d", got.status);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        errors++;
                        $error("status exp %0d got %0d", want.status, got.status);
                    end
                    if (got.creal !== want.creal)
                    begin
                        errors++;
                        $error("cell_real exp %0d got %0d", want.creal, got.creal);
                    end
                    if (got.cimag !== want.cimag)
                    begin
                        errors++;
                        $error("cell_imag exp %0d got %0d", want.cimag, got.cimag);
                    end
                    if (got.ccount !== want.ccount)
                    begin
                        errors++;
                        $error("cell_count exp %0d got %0d", want.ccount, got.ccount);
                    end
                end
            end
            m_tready <= !roll_idle();
        end
        else
            m_tready <= 1'b0;
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("uv_visibility_gridder regression: fail");
            $finish;
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < CELLS; i++)
        begin
            g_re[i] = '0;
            g_im[i] = '0;
            g_hits[i] = '0;
        end
        r_u_scale = 24'd65536;
        r_v_scale = 24'd65536;
        r_min_len = -49'sd1;
        r_max_vis = 32'h8000_0000;
        r_uniform = 1'b0;
        sent = 0;
        quiet_stretch = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = uvg_pkg::CFG_U_SCALE;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_saturation();
        test_random(900, 1'b0);
        test_random(860, 1'b1);
        wait_drained();

        $display("Sent %0d commands, %0d results checked: accumulate, reject paths, reads,",
                 sent, received);
        $display("clears, saturation and both weighting modes under random backpressure.");
        if (errors == 0)
            $display("uv_visibility_gridder regression: pass");
        else
            $display("uv_visibility_gridder regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/uvg_pkg.sv
rtl/core/uvg_div.sv
rtl/core/uvg_datapath.sv
rtl/core/uvg_ctrl.sv
rtl/core/uv_visibility_gridder.sv
tb/uv_visibility_gridder_tb.sv
